[rtl/core/sliding_window_retransmit_tracker_assert.svh]
// Assertion macros for the sliding window retransmit tracker.
// No dependencies; included by the modules that carry assertions.
`ifndef SLIDING_WINDOW_RETRANSMIT_TRACKER_ASSERT_SVH
`define SLIDING_WINDOW_RETRANSMIT_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define SWRT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SWRT_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SWRT_ASSERT(label, clk, rst_n, prop, msg)
`define SWRT_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

[rtl/core/swrt_pkg.sv]
// Package for the sliding window retransmit tracker: action, status, register
// index and state codes and the default interval, used by the top level. No dependencies.
package swrt_pkg;
    typedef enum logic [2:0] {
        ACT_ENQUEUE = 3'd0,
        ACT_ACK     = 3'd1,
        ACT_TIMEOUT = 3'd2,
        ACT_TICK    = 3'd3,
        ACT_SCAN    = 3'd4
    } action_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_TRUNC    = 2'd2;
    localparam logic [1:0] ST_NOTHING  = 2'd3;

    localparam logic [1:0] REG_INTERVAL = 2'd0;
    localparam logic [1:0] REG_FIRST_SEQ = 2'd1;
    localparam logic [1:0] REG_READY_MASK = 2'd2;

    localparam logic [15:0] DEFAULT_INTERVAL = 16'd100;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EVAL,
        S_OUT,
        S_STATUS
    } state_t;
endpackage

[rtl/core/swrt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module swrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/core/sliding_window_retransmit_tracker.sv]
// Sliding window retransmit tracker: sender side of a go-back-N window.
// Depends on swrt_pkg, swrt_ram and sliding_window_retransmit_tracker_assert.svh.
//
// One request is handled at a time. Enqueue, tick, timeout and unknown requests,
// and ack and scan requests on an empty window, go to the status state, which
// registers their status result; the next request is accepted once it is loaded.
// Ack and scan requests otherwise walk the descriptor memory from the oldest
// entry, entry by entry (memory read, then evaluate). A scan holds each sendable
// descriptor back until it knows whether another follows; when one does, the
// held descriptor is loaded as a result first. Result-side stalls can hold any
// of these.
// Sent marks and send times are kept in flip-flops per slot because they are
// cleared by timeout in one step; descriptors and payload live in memories.
module sliding_window_retransmit_tracker #(
    parameter int WINDOW_SLOTS = 16,
    parameter int MAX_PAYLOAD  = 1024,
    parameter int CONNECTIONS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [3:0]  connection_id,
    input  logic [7:0]  payload_byte,
    input  logic        last_byte,
    input  logic [31:0] ack_sequence,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [1:0]  status,
    output logic [3:0]  slot,
    output logic [31:0] sequence_res,
    output logic [10:0] payload_length,
    output logic [3:0]  tx_connection,
    output logic [4:0]  occupancy,
    output logic        last_result
);
    import swrt_pkg::*;
    `include "sliding_window_retransmit_tracker_assert.svh"

    localparam int IW = $clog2(WINDOW_SLOTS);
    localparam int CW = $clog2(WINDOW_SLOTS + 1);
    localparam int FW = $clog2(MAX_PAYLOAD + 1);
    localparam int PW = $clog2(MAX_PAYLOAD);
    localparam int DW = 32 + FW + 4;

    state_t state_reg, state_next;

    logic [15:0] interval_reg;
    logic [15:0] mask_reg;
    logic [31:0] next_seq_reg;
    logic [31:0] clock_reg;
    logic [IW-1:0] head_reg, tail_reg;
    logic [CW-1:0] count_reg;
    logic [FW-1:0] fill_reg;
    logic [WINDOW_SLOTS-1:0] sent_reg;
    logic [31:0] last_sent_reg [WINDOW_SLOTS];

    logic [2:0]  act_reg;
    logic [31:0] ack_reg;
    logic [1:0]  stat_reg;
    logic [CW-1:0] walk_reg;
    logic [IW-1:0] idx_reg;
    logic        any_sent_reg;
    logic        more_reg;

    logic        o_valid_reg;
    logic        o_kind_reg;
    logic [1:0]  o_status_reg;
    logic [3:0]  o_slot_reg;
    logic [31:0] o_seq_reg;
    logic [10:0] o_len_reg;
    logic [3:0]  o_conn_reg;
    logic [4:0]  o_occ_reg;
    logic        o_last_reg;

    logic [IW-1:0] o_slot_reg_hold;
    logic [31:0]   o_seq_hold;
    logic [10:0]   o_len_hold;
    logic [3:0]    o_conn_hold;

    // Descriptor memory: sequence, length and connection of each slot.
    logic          d_we;
    logic [IW-1:0] d_waddr;
    logic [DW-1:0] d_wdata, d_rdata;
    logic [31:0]   rd_seq;
    logic [FW-1:0] rd_len;
    logic [3:0]    rd_conn;

    swrt_ram #(.WIDTH(DW), .DEPTH(WINDOW_SLOTS)) u_desc (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (idx_reg),
        .rdata (d_rdata)
    );

    assign rd_seq  = d_rdata[DW-1 -: 32];
    assign rd_len  = d_rdata[4 +: FW];
    assign rd_conn = d_rdata[3:0];

    // Payload store; the payload is never read out here, only stored.
    logic [IW+PW-1:0] p_addr;
    logic [7:0] p_rdata;
    logic       p_we;

    swrt_ram #(.WIDTH(8), .DEPTH(WINDOW_SLOTS * MAX_PAYLOAD)) u_payload (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_addr),
        .wdata (payload_byte),
        .raddr (p_addr),
        .rdata (p_rdata)
    );

    logic in_acc, cfg_acc, out_acc;
    logic full, room;
    logic conn_ok, sendable;
    logic o_load;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = o_valid_reg && !out_stall;
    assign o_load    = ((state_reg == S_OUT) || (state_reg == S_STATUS))
                       && (!o_valid_reg || out_acc);
    assign full      = (count_reg == CW'(WINDOW_SLOTS));
    assign room      = (fill_reg < FW'(MAX_PAYLOAD));
    assign p_we      = in_acc && (action == ACT_ENQUEUE) && !full && room;
    assign p_addr    = {head_reg, fill_reg[PW-1:0]};

    assign d_we    = p_we ? last_byte : (in_acc && action == ACT_ENQUEUE && !full && last_byte);
    assign d_waddr = head_reg;
    assign d_wdata = {next_seq_reg, (room ? fill_reg + FW'(1) : fill_reg), connection_id};

    assign conn_ok  = (32'(rd_conn) < 32'(CONNECTIONS)) && mask_reg[rd_conn];
    assign sendable = conn_ok && !(sent_reg[idx_reg] && last_sent_reg[idx_reg] != 32'd0
                      && (clock_reg - last_sent_reg[idx_reg]) < {16'd0, interval_reg});

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (action == ACT_ACK || action == ACT_SCAN)
                    begin
                        state_next = (count_reg != '0) ? S_RD : S_STATUS;
                    end
                    else
                    begin
                        state_next = S_STATUS;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (act_reg == ACT_ACK)
                begin
                    if (rd_seq <= ack_reg && count_reg > CW'(1))
                        state_next = S_RD;
                    else
                        state_next = S_STATUS;
                end
                else if (sendable && any_sent_reg)
                begin
                    state_next = S_OUT;
                end
                else if (walk_reg > CW'(1))
                begin
                    state_next = S_RD;
                end
                else if (sendable || any_sent_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_STATUS;
                end
            end
            S_OUT:
            begin
                if (!o_valid_reg || out_acc)
                    state_next = more_reg ? S_EVAL : S_IDLE;
            end
            S_STATUS:
            begin
                if (!o_valid_reg || out_acc)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            interval_reg <= DEFAULT_INTERVAL;
            mask_reg     <= '0;
            next_seq_reg <= '0;
            clock_reg    <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            fill_reg     <= '0;
            sent_reg     <= '0;
            o_valid_reg  <= 1'b0;
            any_sent_reg <= 1'b0;
            more_reg     <= 1'b0;
            for (int i = 0; i < WINDOW_SLOTS; i++)
            begin
                last_sent_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (o_load)
                o_valid_reg <= 1'b1;
            else if (out_acc)
                o_valid_reg <= 1'b0;

            if (cfg_acc)
            begin
                unique case (cfg_index)
                    REG_INTERVAL:   interval_reg <= cfg_data[15:0];
                    REG_FIRST_SEQ:  next_seq_reg <= cfg_data;
                    REG_READY_MASK: mask_reg <= cfg_data[15:0];
                    default:        ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        act_reg      <= action;
                        ack_reg      <= ack_sequence;
                        idx_reg      <= tail_reg;
                        walk_reg     <= count_reg;
                        any_sent_reg <= 1'b0;
                        case (action)
                            ACT_ENQUEUE:
                            begin
                                if (full)
                                begin
                                    stat_reg <= ST_FULL;
                                    if (last_byte)
                                        fill_reg <= '0;
                                end
                                else
                                begin
                                    stat_reg <= room ? ST_OK : ST_TRUNC;
                                    if (last_byte)
                                    begin
                                        next_seq_reg <= next_seq_reg + 32'd1;
                                        last_sent_reg[head_reg] <= '0;
                                        sent_reg[head_reg] <= 1'b0;
                                        head_reg <= (head_reg == IW'(WINDOW_SLOTS - 1))
                                                    ? '0 : head_reg + IW'(1);
                                        count_reg <= count_reg + CW'(1);
                                        fill_reg <= '0;
                                    end
                                    else if (room)
                                    begin
                                        fill_reg <= fill_reg + FW'(1);
                                    end
                                end
                            end
                            ACT_TIMEOUT:
                            begin
                                stat_reg <= ST_OK;
                                sent_reg <= '0;
                                for (int i = 0; i < WINDOW_SLOTS; i++)
                                begin
                                    last_sent_reg[i] <= '0;
                                end
                            end
                            ACT_TICK:
                            begin
                                stat_reg <= ST_OK;
                                clock_reg <= clock_reg + 32'd1;
                            end
                            ACT_SCAN:
                            begin
                                stat_reg <= (count_reg == '0) ? ST_NOTHING : ST_OK;
                            end
                            default:
                            begin
                                stat_reg <= ST_OK;
                            end
                        endcase
                    end
                end
                S_RD:
                begin
                end
                S_EVAL:
                begin
                    if (act_reg == ACT_ACK)
                    begin
                        if (rd_seq <= ack_reg)
                        begin
                            last_sent_reg[idx_reg] <= '0;
                            sent_reg[idx_reg] <= 1'b0;
                            tail_reg <= (tail_reg == IW'(WINDOW_SLOTS - 1))
                                        ? '0 : tail_reg + IW'(1);
                            idx_reg <= (idx_reg == IW'(WINDOW_SLOTS - 1))
                                       ? '0 : idx_reg + IW'(1);
                            count_reg <= count_reg - CW'(1);
                        end
                    end
                    else if (sendable && any_sent_reg)
                    begin
                        // Another descriptor follows, so the held one goes out
                        // first; this entry is evaluated again afterwards.
                        more_reg <= 1'b1;
                    end
                    else
                    begin
                        if (sendable)
                        begin
                            last_sent_reg[idx_reg] <= clock_reg;
                            sent_reg[idx_reg] <= 1'b1;
                            any_sent_reg <= 1'b1;
                            o_slot_reg_hold <= idx_reg;
                            o_seq_hold <= rd_seq;
                            o_len_hold <= 11'(rd_len);
                            o_conn_hold <= rd_conn;
                        end
                        else if (walk_reg <= CW'(1) && !any_sent_reg)
                        begin
                            stat_reg <= ST_NOTHING;
                        end
                        more_reg <= 1'b0;
                        walk_reg <= walk_reg - CW'(1);
                        idx_reg <= (idx_reg == IW'(WINDOW_SLOTS - 1))
                                   ? '0 : idx_reg + IW'(1);
                    end
                end
                S_OUT:
                begin
                    if (o_load)
                    begin
                        o_kind_reg   <= 1'b1;
                        o_status_reg <= ST_OK;
                        o_slot_reg   <= 4'(o_slot_reg_hold);
                        o_seq_reg    <= o_seq_hold;
                        o_len_reg    <= o_len_hold;
                        o_conn_reg   <= o_conn_hold;
                        o_occ_reg    <= 5'(count_reg);
                        o_last_reg   <= !more_reg;
                        any_sent_reg <= 1'b0;
                    end
                end
                S_STATUS:
                begin
                    if (o_load)
                    begin
                        o_kind_reg   <= 1'b0;
                        o_status_reg <= stat_reg;
                        o_slot_reg   <= '0;
                        o_seq_reg    <= '0;
                        o_len_reg    <= '0;
                        o_conn_reg   <= '0;
                        o_occ_reg    <= 5'(count_reg);
                        o_last_reg   <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // The payload memory is write-only here; its read data is left unused.
    logic unused_rdata;
    assign unused_rdata = ^p_rdata;

    assign out_valid      = o_valid_reg;
    assign kind           = o_kind_reg;
    assign status         = o_status_reg;
    assign slot           = o_slot_reg;
    assign sequence_res   = o_seq_reg;
    assign payload_length = o_len_reg;
    assign tx_connection  = o_conn_reg;
    assign occupancy      = o_occ_reg;
    assign last_result    = o_last_reg;

    `SWRT_ASSERT(a_count_range, clk, rst_n, count_reg <= CW'(WINDOW_SLOTS),
        "window occupancy beyond the slot count")
    `SWRT_ASSERT(a_stall_busy, clk, rst_n, (state_reg != S_IDLE) |-> in_stall,
        "request accepted while a walk is in progress")
    `SWRT_ASSERT_NEVER(a_fill_range, clk, rst_n, fill_reg > FW'(MAX_PAYLOAD),
        "fill offset beyond maximum payload")
    `SWRT_ASSERT(a_hold_out, clk, rst_n, (o_valid_reg && out_stall) |=> o_valid_reg,
        "result dropped while stalled")
endmodule
